@@ rtl/assert_macros.svh @@
// Assertion macros for the NAT flow table RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/npft_pkg.sv @@
// Package for the NAT port flow table: sizes, payload structs, state enum.
// No dependencies.
package npft_pkg;
    localparam int TableEntries = 1024;
    localparam int Ways = 4;
    localparam int Sets = TableEntries / Ways;
    localparam int SetW = $clog2(Sets);
    localparam int WayW = (Ways > 1) ? $clog2(Ways) : 1;
    localparam logic [31:0] PublicIpReset = 32'hC0A8_0101;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic        fin_flag;
    } in_item_t;

    typedef struct packed {
        logic [31:0] new_source_ip;
        logic [15:0] mapped_port;
        logic        flow_hit;
        logic        entry_removed;
        logic        entry_added;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [15:0] port;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OUTPUT
    } state_t;

    function automatic logic [SetW-1:0] set_of(input key_t k);
        logic [32:0] h;
        h = {1'b0, k.sip} ^ {k.dip, 1'b0} ^ {16'd0, k.sport, 1'b0}
            ^ {16'd0, k.dport, 1'b0};
        return h[SetW-1:0];
    endfunction
endpackage

@@ rtl/npft_set_ram.sv @@
// One set-wide RAM: all ways of a set in one row, registered read.
// Depends on npft_pkg.
module npft_set_ram (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [npft_pkg::SetW-1:0]             wr_addr,
    input  npft_pkg::entry_t [npft_pkg::Ways-1:0] wr_data,
    input  logic [npft_pkg::SetW-1:0]             rd_addr,
    output npft_pkg::entry_t [npft_pkg::Ways-1:0] rd_data
);
    npft_pkg::entry_t [npft_pkg::Ways-1:0] mem [npft_pkg::Sets];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ rtl/nat_port_flow_table.sv @@
// NAT port flow table top level: FSM, valid RAM, set RAM, result register.
// Depends on npft_pkg, npft_set_ram, assert_macros.svh.
//
// channel   dir  handshake              payload
// cfg       in   cfg_valid/cfg_ready    cfg_data (public source IP)
// in        in   in_valid/in_ready      in_item  (npft_pkg::in_item_t)
// out       out  out_valid/out_ready    out_item (npft_pkg::out_item_t)
//
// An item passes through accept with the set read, then update, then result.
// The result waits in the output register until taken; the next item is
// accepted in the cycle after it leaves.
// After reset a clearing pass over all Sets (256) rows zeroes the valid RAM;
// no item is taken during it, configuration writes are.
// Set RAM and valid RAM are read and written one row per cycle.
`include "assert_macros.svh"
module nat_port_flow_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  npft_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output npft_pkg::out_item_t  out_item
);
    localparam int SetW = npft_pkg::SetW;
    localparam int Ways = npft_pkg::Ways;

    npft_pkg::state_t state_reg, state_next;
    logic [SetW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [31:0]      pub_ip_reg;
    logic [15:0]      counter_reg, counter_next;
    npft_pkg::in_item_t  item_reg;
    npft_pkg::out_item_t out_reg, out_next;
    logic [SetW-1:0]  set_idx;
    npft_pkg::key_t   key;
    npft_pkg::key_t   in_key;
    logic [SetW-1:0]  in_set;
    logic [SetW-1:0]  rd_set;

    npft_pkg::entry_t [Ways-1:0] rd_row, wr_row;
    logic                        row_we;
    logic [Ways-1:0]             valid_mem [npft_pkg::Sets];
    logic [Ways-1:0]             vrd_reg, vwr;
    logic                        vwe;
    logic [SetW-1:0]             vaddr;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == npft_pkg::ST_IDLE);
    assign out_valid = (state_reg == npft_pkg::ST_OUTPUT);
    assign out_item  = out_reg;
    assign key = '{sip: item_reg.source_ip, dip: item_reg.destination_ip,
                   sport: item_reg.source_port, dport: item_reg.destination_port};
    assign set_idx = npft_pkg::set_of(key);
    assign in_key = '{sip: in_item.source_ip, dip: in_item.destination_ip,
                      sport: in_item.source_port, dport: in_item.destination_port};
    assign in_set = npft_pkg::set_of(in_key);
    // read the set of the incoming item at its accept edge
    assign rd_set = in_ready ? in_set : set_idx;

    npft_set_ram u_ram (
        .clk     (clk),
        .wr_en   (row_we),
        .wr_addr (set_idx),
        .wr_data (wr_row),
        .rd_addr (rd_set),
        .rd_data (rd_row)
    );

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            valid_mem[vaddr] <= vwr;
        end
        vrd_reg <= valid_mem[rd_set];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= npft_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            counter_reg <= '0;
            pub_ip_reg  <= npft_pkg::PublicIpReset;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            counter_reg <= counter_next;
            if (cfg_valid && cfg_ready)
            begin
                pub_ip_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        out_reg <= out_next;
    end

    always_comb
    begin
        logic          hit, free_found;
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        counter_next = counter_reg;
        out_next     = out_reg;
        wr_row       = rd_row;
        row_we       = 1'b0;
        vwe          = 1'b0;
        vaddr        = set_idx;
        vwr          = vrd_reg;
        hit          = 1'b0;
        free_found   = 1'b0;
        unique case (state_reg)
            npft_pkg::ST_CLEAR:
            begin
                vwe          = 1'b1;
                vaddr        = clr_cnt_reg;
                vwr          = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SetW'(npft_pkg::Sets - 1))
                begin
                    state_next = npft_pkg::ST_IDLE;
                end
            end
            npft_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = npft_pkg::ST_LOOKUP;
                end
            end
            npft_pkg::ST_LOOKUP:
            begin
                out_next = '0;
                out_next.new_source_ip = pub_ip_reg;
                for (int w = 0; w < Ways; w++)
                begin
                    if (vrd_reg[w] && !hit && rd_row[w].key == key)
                    begin
                        hit = 1'b1;
                        out_next.mapped_port = rd_row[w].port;
                        if (item_reg.fin_flag)
                        begin
                            vwr[w] = 1'b0;
                        end
                    end
                end
                if (hit)
                begin
                    out_next.flow_hit      = 1'b1;
                    out_next.entry_removed = item_reg.fin_flag;
                    vwe                    = item_reg.fin_flag;
                end
                else
                begin
                    out_next.mapped_port = counter_reg;
                    counter_next         = counter_reg + 16'd1;
                    if (!item_reg.fin_flag)
                    begin
                        for (int w = 0; w < Ways; w++)
                        begin
                            if (!vrd_reg[w] && !free_found)
                            begin
                                free_found = 1'b1;
                                vwr[w]     = 1'b1;
                                wr_row[w]  = '{key: key, port: counter_reg};
                            end
                        end
                        out_next.entry_added = free_found;
                        out_next.table_full  = !free_found;
                        vwe                  = free_found;
                        row_we               = free_found;
                    end
                end
                state_next = npft_pkg::ST_OUTPUT;
            end
            npft_pkg::ST_OUTPUT:
            begin
                if (out_ready)
                begin
                    state_next = npft_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npft_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_take_then_lookup, clk, rst_n, in_valid && in_ready,
        state_reg == npft_pkg::ST_LOOKUP)
    `ASSERT_IMPLIES(a_flags_excl, clk, rst_n, out_valid,
        !(out_item.entry_added && (out_item.flow_hit || out_item.table_full)))
    `ASSERT_IMPLIES(a_removed_hit, clk, rst_n, out_valid && out_item.entry_removed,
        out_item.flow_hit)
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_item))
endmodule
